>>> hw/rtl/hm_pkg.sv
`default_nettype none
package hm_pkg;

  localparam int ID_W = 10;
  localparam int ID_DEPTH = 1024;
  localparam int KEY_W = 62;
  localparam int CNT_W = 11;

  localparam logic [2:0] K_APPEND = 3'd0;
  localparam logic [2:0] K_BUILD = 3'd1;
  localparam logic [2:0] K_UPDATE = 3'd2;
  localparam logic [2:0] K_DROP = 3'd3;
  localparam logic [2:0] K_PARK = 3'd4;
  localparam logic [2:0] K_RESTORE = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [ID_W-1:0] entry_id;
    logic [30:0] cost_bits;
    logic [30:0] length_bits;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [ID_W-1:0] top_id;
    logic [30:0] top_cost_bits;
    logic [30:0] top_length_bits;
    logic [CNT_W-1:0] active_count;
    logic [CNT_W-1:0] parked_count;
  } out_t;

endpackage
`default_nettype wire

>>> hw/rtl/hm_ram.sv
`default_nettype none
module hm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/indexed_min_heap_with_parking.sv
`default_nettype none
// Indexed binary min-heap with a parking area behind the active entries.
// Input: a request is taken when start is high and busy is low; busy stays
// high until the result for that request has been given.
// Output: one result per request, shown for a single cycle with out_valid.
// The receiver cannot stall; the result must be taken in that cycle.
// Work per request: peek, append and rejected requests run no sift. An update
// runs one sift, up and then down; a drop or park runs one sift unless the
// entry was in the last active slot. Build runs one sift down for each of
// active/2 slots; restore runs one sift per parked entry. Each step waits on
// the single read port on each of the slot, position and key memories, each
// read being registered.
// Reset: the counts clear at once, then a clearing pass writes every entry of
// the position memory as absent, with busy held high.
module indexed_min_heap_with_parking import hm_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = $clog2(MAX_ENTRIES + 2);
  localparam logic [PW-1:0] POS_ABSENT = '0;
  localparam logic [PW-1:0] POS_PARKED = '1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_AP0, S_AP1, S_AP2, S_BLD, S_RS,
    S_LD0, S_LD1, S_LD2, S_U0, S_U1, S_U2,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_FIN,
    S_TK0, S_TK1, S_TK2, S_TK3, S_TK4, S_TK5,
    S_RES0, S_RES1, S_RES2
  } state_t;

  state_t state_r, ret_r;
  in_t req_r;
  logic [1:0] st_r;
  logic [SW-1:0] active_r, parked_r, i_r, k_r, c_r;
  logic [ID_W-1:0] clr_r, e_r, pid_r, cid_r, rid_r, mv_r, tail_r, tid_r;
  logic [KEY_W-1:0] ekey_r, ckey_r;
  logic up_r, park_r;

  logic s_we, s_re, p_we, p_re, k_we, k_re;
  logic [SW-1:0] s_wa, s_ra;
  logic [ID_W-1:0] s_wd, s_rd, p_wa, p_ra, k_wa, k_ra;
  logic [PW-1:0] p_wd, p_rd;
  logic [KEY_W-1:0] k_wd, k_rd;

  hm_ram #(.W(ID_W), .D(MAX_ENTRIES + 1)) u_slot (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .re(s_re), .raddr(s_ra), .rdata(s_rd)
  );
  hm_ram #(.W(PW), .D(ID_DEPTH)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .re(p_re), .raddr(p_ra), .rdata(p_rd)
  );
  hm_ram #(.W(KEY_W), .D(ID_DEPTH)) u_key (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .re(k_re), .raddr(k_ra), .rdata(k_rd)
  );

  logic [KEY_W-1:0] kin;
  logic id_ok, p_abs, p_prk, p_act, dn_ok, rt_ok, full, tk_move;
  logic [SW:0] two_i, two_i1, n_ext;
  logic [SW-1:0] a_nxt, pos_slot;

  assign kin = {req_r.cost_bits, req_r.length_bits};
  assign id_ok = 32'(req_r.entry_id) < MAX_ENTRIES;
  assign p_abs = p_rd == POS_ABSENT;
  assign p_prk = p_rd == POS_PARKED;
  assign p_act = id_ok && !p_abs && !p_prk;
  assign pos_slot = SW'(p_rd);
  assign two_i = {i_r, 1'b0};
  assign two_i1 = {i_r, 1'b1};
  assign n_ext = {1'b0, active_r};
  assign dn_ok = two_i <= n_ext;
  assign rt_ok = two_i1 <= n_ext;
  assign full = ({1'b0, active_r} + {1'b0, parked_r}) >= (SW+1)'(MAX_ENTRIES);
  assign a_nxt = active_r + SW'(1);
  assign tk_move = i_r < active_r;
  assign busy = state_r != S_IDLE;

  always_comb begin
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_re = 1'b0; s_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_re = 1'b0; p_ra = '0;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_re = 1'b0; k_ra = '0;
    case (state_r)
      S_CLR: begin
        p_we = 1'b1; p_wa = clr_r; p_wd = POS_ABSENT;
      end
      S_IDLE: begin
        p_re = start; p_ra = in_data.entry_id;
      end
      S_DISP: begin
        if ((req_r.kind == K_APPEND || req_r.kind == K_UPDATE) && id_ok && !p_abs) begin
          k_we = 1'b1; k_wa = req_r.entry_id; k_wd = kin;
        end
      end
      S_AP0: begin
        s_re = parked_r != '0; s_ra = a_nxt;
      end
      S_AP1: begin
        s_we = 1'b1; s_wa = a_nxt + parked_r; s_wd = s_rd;
      end
      S_AP2: begin
        s_we = 1'b1; s_wa = a_nxt; s_wd = req_r.entry_id;
        p_we = 1'b1; p_wa = req_r.entry_id; p_wd = PW'(a_nxt);
        k_we = 1'b1; k_wa = req_r.entry_id; k_wd = kin;
      end
      S_LD0: begin
        s_re = 1'b1; s_ra = i_r;
      end
      S_LD1: begin
        k_re = 1'b1; k_ra = s_rd;
      end
      S_U0: begin
        s_re = up_r && i_r > SW'(1); s_ra = i_r >> 1;
      end
      S_U1: begin
        k_re = 1'b1; k_ra = s_rd;
      end
      S_U2: begin
        if (ekey_r < k_rd) begin
          s_we = 1'b1; s_wa = i_r; s_wd = pid_r;
          p_we = 1'b1; p_wa = pid_r; p_wd = PW'(i_r);
        end
      end
      S_D0: begin
        s_re = dn_ok; s_ra = SW'(two_i);
      end
      S_D1: begin
        k_re = 1'b1; k_ra = s_rd;
        s_re = rt_ok; s_ra = SW'(two_i1);
      end
      S_D2: begin
        k_re = rt_ok; k_ra = s_rd;
      end
      S_D4: begin
        if (ckey_r < ekey_r) begin
          s_we = 1'b1; s_wa = i_r; s_wd = cid_r;
          p_we = 1'b1; p_wa = cid_r; p_wd = PW'(i_r);
        end
      end
      S_FIN: begin
        s_we = 1'b1; s_wa = i_r; s_wd = e_r;
        p_we = 1'b1; p_wa = e_r; p_wd = PW'(i_r);
      end
      S_TK0: begin
        s_re = 1'b1; s_ra = active_r;
      end
      S_TK1: begin
        s_re = !park_r && parked_r != '0; s_ra = active_r + parked_r;
      end
      S_TK3: begin
        if (tk_move) begin
          s_we = 1'b1; s_wa = i_r; s_wd = mv_r;
          p_we = 1'b1; p_wa = mv_r; p_wd = PW'(i_r);
        end
      end
      S_TK4: begin
        s_we = park_r || parked_r != '0; s_wa = active_r;
        s_wd = park_r ? req_r.entry_id : tail_r;
        p_we = 1'b1; p_wa = req_r.entry_id; p_wd = park_r ? POS_PARKED : POS_ABSENT;
        k_re = tk_move; k_ra = mv_r;
      end
      S_RES0: begin
        s_re = active_r != '0; s_ra = SW'(1);
      end
      S_RES1: begin
        k_re = 1'b1; k_ra = s_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r <= S_RES0;
      clr_r <= '0;
      active_r <= '0;
      parked_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + ID_W'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r <= in_data;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          st_r <= ST_OK;
          state_r <= S_RES0;
          case (req_r.kind)
            K_APPEND: begin
              if (!id_ok) st_r <= ST_INACTIVE;
              else if (!p_abs) st_r <= ST_OK;
              else if (full) st_r <= ST_FULL;
              else state_r <= S_AP0;
            end
            K_BUILD: begin
              k_r <= active_r >> 1;
              state_r <= S_BLD;
            end
            K_UPDATE: begin
              if (!p_act) st_r <= ST_INACTIVE;
              else begin
                e_r <= req_r.entry_id;
                ekey_r <= kin;
                i_r <= pos_slot;
                up_r <= 1'b1;
                ret_r <= S_RES0;
                state_r <= S_U0;
              end
            end
            K_DROP, K_PARK: begin
              if (!p_act) st_r <= ST_INACTIVE;
              else begin
                i_r <= pos_slot;
                park_r <= req_r.kind == K_PARK;
                state_r <= S_TK0;
              end
            end
            K_RESTORE: state_r <= S_RS;
            default: state_r <= S_RES0;
          endcase
        end
        S_AP0: state_r <= (parked_r != '0) ? S_AP1 : S_AP2;
        S_AP1: state_r <= S_AP2;
        S_AP2: begin
          active_r <= a_nxt;
          state_r <= S_RES0;
        end
        S_BLD: begin
          if (k_r == '0) state_r <= S_RES0;
          else begin
            i_r <= k_r;
            k_r <= k_r - SW'(1);
            up_r <= 1'b0;
            ret_r <= S_BLD;
            state_r <= S_LD0;
          end
        end
        S_RS: begin
          if (parked_r == '0) state_r <= S_RES0;
          else begin
            parked_r <= parked_r - SW'(1);
            active_r <= a_nxt;
            i_r <= a_nxt;
            up_r <= 1'b1;
            ret_r <= S_RS;
            state_r <= S_LD0;
          end
        end
        S_LD0: state_r <= S_LD1;
        S_LD1: begin
          e_r <= s_rd;
          state_r <= S_LD2;
        end
        S_LD2: begin
          ekey_r <= k_rd;
          state_r <= S_U0;
        end
        S_U0: state_r <= (up_r && i_r > SW'(1)) ? S_U1 : S_D0;
        S_U1: begin
          pid_r <= s_rd;
          state_r <= S_U2;
        end
        S_U2: begin
          if (ekey_r < k_rd) begin
            i_r <= i_r >> 1;
            state_r <= S_U0;
          end else state_r <= S_D0;
        end
        S_D0: begin
          c_r <= SW'(two_i);
          state_r <= dn_ok ? S_D1 : S_FIN;
        end
        S_D1: begin
          cid_r <= s_rd;
          state_r <= S_D2;
        end
        S_D2: begin
          ckey_r <= k_rd;
          rid_r <= s_rd;
          state_r <= rt_ok ? S_D3 : S_D4;
        end
        S_D3: begin
          if (k_rd < ckey_r) begin
            cid_r <= rid_r;
            ckey_r <= k_rd;
            c_r <= SW'(two_i1);
          end
          state_r <= S_D4;
        end
        S_D4: begin
          if (ckey_r < ekey_r) begin
            i_r <= c_r;
            state_r <= S_D0;
          end else state_r <= S_FIN;
        end
        S_FIN: state_r <= ret_r;
        S_TK0: state_r <= S_TK1;
        S_TK1: begin
          mv_r <= s_rd;
          state_r <= (!park_r && parked_r != '0) ? S_TK2 : S_TK3;
        end
        S_TK2: begin
          tail_r <= s_rd;
          state_r <= S_TK3;
        end
        S_TK3: state_r <= S_TK4;
        S_TK4: begin
          if (park_r) parked_r <= parked_r + SW'(1);
          active_r <= active_r - SW'(1);
          if (tk_move) begin
            e_r <= mv_r;
            up_r <= 1'b1;
            ret_r <= S_RES0;
            state_r <= S_TK5;
          end else state_r <= S_RES0;
        end
        S_TK5: begin
          ekey_r <= k_rd;
          state_r <= S_U0;
        end
        S_RES0: begin
          if (active_r == '0) begin
            out_valid <= 1'b1;
            out_data.status <= (st_r == ST_OK &&
                (req_r.kind == K_BUILD || req_r.kind >= K_RESTORE)) ? ST_EMPTY : st_r;
            out_data.top_id <= '0;
            out_data.top_cost_bits <= '0;
            out_data.top_length_bits <= '0;
            out_data.active_count <= CNT_W'(active_r);
            out_data.parked_count <= CNT_W'(parked_r);
            state_r <= S_IDLE;
          end else state_r <= S_RES1;
        end
        S_RES1: begin
          tid_r <= s_rd;
          state_r <= S_RES2;
        end
        S_RES2: begin
          out_valid <= 1'b1;
          out_data.status <= st_r;
          out_data.top_id <= tid_r;
          out_data.top_cost_bits <= k_rd[KEY_W-1:31];
          out_data.top_length_bits <= k_rd[30:0];
          out_data.active_count <= CNT_W'(active_r);
          out_data.parked_count <= CNT_W'(parked_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
  import hm_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int N_RANDOM = 1030;
  localparam logic [2:0] K_PEEK = 3'd6;
  localparam logic [2:0] K_NOP = 3'd7;
  localparam int POS_ABSENT = 0;
  localparam int POS_PARKED = -1;
  localparam logic [30:0] KEY_MAX = 31'd2139095040;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;

  indexed_min_heap_with_parking u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // heap shadow
  logic [9:0] slot_id [1:ID_DEPTH];
  int pos_of [ID_DEPTH];
  logic [30:0] cost_of [ID_DEPTH];
  logic [30:0] len_of [ID_DEPTH];
  int n_active;
  int n_parked;

  out_t pending_results[$];
  int errors;
  int cycles;
  int n_requests;
  int kind_seen [8];

  function automatic bit key_lt(logic [9:0] a, logic [9:0] b);
    if (cost_of[a] != cost_of[b]) return cost_of[a] < cost_of[b];
    return len_of[a] < len_of[b];
  endfunction

  function automatic void place(int k, logic [9:0] id);
    slot_id[k] = id;
    pos_of[id] = k;
  endfunction

  function automatic void sift(int i, bit up);
    logic [9:0] e;
    int p;
    int c;
    e = slot_id[i];
    while (up && i > 1) begin
      p = i >> 1;
      if (!key_lt(e, slot_id[p])) break;
      place(i, slot_id[p]);
      i = p;
    end
    while ((i << 1) <= n_active) begin
      c = i << 1;
      if (c + 1 <= n_active && key_lt(slot_id[c + 1], slot_id[c])) c++;
      if (!key_lt(slot_id[c], e)) break;
      place(i, slot_id[c]);
      i = c;
    end
    place(i, e);
  endfunction

  function automatic void remove_at(int i, bit park);
    int last;
    logic [9:0] e;
    last = n_active;
    e = slot_id[i];
    slot_id[i] = slot_id[last];
    if (park) begin
      slot_id[last] = e;
      pos_of[e] = POS_PARKED;
      n_parked++;
    end else begin
      if (n_parked > 0) slot_id[last] = slot_id[last + n_parked];
      pos_of[e] = POS_ABSENT;
    end
    n_active--;
    if (i < last) begin
      pos_of[slot_id[i]] = i;
      sift(i, 1'b1);
    end
  endfunction

  function automatic out_t heap_apply(in_t r);
    out_t o;
    int p;
    int a;
    bit act;
    logic [1:0] st;
    st = ST_OK;
    p = pos_of[r.entry_id];
    act = (p != POS_ABSENT) && (p != POS_PARKED);
    case (r.kind)
      K_APPEND: begin
        if (p != POS_ABSENT) begin
          cost_of[r.entry_id] = r.cost_bits;
          len_of[r.entry_id] = r.length_bits;
        end else if (n_active + n_parked >= ID_DEPTH) begin
          st = ST_FULL;
        end else begin
          a = n_active + 1;
          if (n_parked > 0) slot_id[a + n_parked] = slot_id[a];
          cost_of[r.entry_id] = r.cost_bits;
          len_of[r.entry_id] = r.length_bits;
          place(a, r.entry_id);
          n_active = a;
        end
      end
      K_BUILD: begin
        for (int k = n_active >> 1; k >= 1; k--) sift(k, 1'b0);
      end
      K_UPDATE: begin
        if (p == POS_ABSENT) begin
          st = ST_INACTIVE;
        end else begin
          cost_of[r.entry_id] = r.cost_bits;
          len_of[r.entry_id] = r.length_bits;
          if (act) sift(p, 1'b1);
          else st = ST_INACTIVE;
        end
      end
      K_DROP, K_PARK: begin
        if (act) remove_at(p, r.kind == K_PARK);
        else st = ST_INACTIVE;
      end
      K_RESTORE: begin
        while (n_parked > 0) begin
          n_parked--;
          n_active++;
          sift(n_active, 1'b1);
        end
      end
      default: ;
    endcase
    if (st == ST_OK && n_active == 0 && (r.kind == K_BUILD || r.kind >= K_RESTORE))
      st = ST_EMPTY;
    o = '0;
    o.status = st;
    if (n_active > 0) begin
      o.top_id = slot_id[1];
      o.top_cost_bits = cost_of[slot_id[1]];
      o.top_length_bits = len_of[slot_id[1]];
    end
    o.active_count = n_active[CNT_W-1:0];
    o.parked_count = n_parked[CNT_W-1:0];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch @%0d %s: got %0h expected %0h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(out_data.top_id), '0);
      end else begin
        out_t w;
        w = pending_results.pop_front();
        if (out_data.status != w.status)
          report("status", 64'(out_data.status), 64'(w.status));
        if (out_data.top_id != w.top_id)
          report("top_id", 64'(out_data.top_id), 64'(w.top_id));
        if (out_data.top_cost_bits != w.top_cost_bits)
          report("top_cost_bits", 64'(out_data.top_cost_bits), 64'(w.top_cost_bits));
        if (out_data.top_length_bits != w.top_length_bits)
          report("top_length_bits", 64'(out_data.top_length_bits),
                 64'(w.top_length_bits));
        if (out_data.active_count != w.active_count)
          report("active_count", 64'(out_data.active_count), 64'(w.active_count));
        if (out_data.parked_count != w.parked_count)
          report("parked_count", 64'(out_data.parked_count), 64'(w.parked_count));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // present the request from the falling edge until it is taken
  task automatic send(in_t r, bit has_fixed, out_t fixed, bit allow_gap);
    out_t pred;
    int gap;
    in_data = r;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pred = heap_apply(r);
    pending_results.push_back(has_fixed ? fixed : pred);
    n_requests++;
    kind_seen[r.kind]++;
    @(negedge clk);
    if (allow_gap && $urandom_range(0, 99) < 13) begin
      start = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic in_t mk(logic [2:0] k, logic [9:0] id, logic [30:0] c, logic [30:0] l);
    in_t r;
    r.kind = k;
    r.entry_id = id;
    r.cost_bits = c;
    r.length_bits = l;
    return r;
  endfunction

  typedef struct {
    in_t req;
    bit fixed;
    out_t res;
  } row_t;

  function automatic out_t mkres(logic [1:0] st, int act);
    out_t o;
    o = '0;
    o.status = st;
    o.active_count = act[CNT_W-1:0];
    return o;
  endfunction

  row_t plan[$];
  in_t r;
  int roll;
  logic [9:0] rid;

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    n_requests = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    for (int k = 0; k < ID_DEPTH; k++) begin
      pos_of[k] = POS_ABSENT;
      cost_of[k] = '0;
      len_of[k] = '0;
    end
    n_active = 0;
    n_parked = 0;

    plan.push_back('{mk(K_PEEK, 10'd0, 31'd0, 31'd0), 1, mkres(ST_EMPTY, 0)});
    plan.push_back('{mk(K_BUILD, 10'd0, 31'd0, 31'd0), 1, mkres(ST_EMPTY, 0)});
    plan.push_back('{mk(K_RESTORE, 10'd0, 31'd0, 31'd0), 1, mkres(ST_EMPTY, 0)});
    plan.push_back('{mk(K_NOP, 10'd3, 31'd1, 31'd1), 1, mkres(ST_EMPTY, 0)});
    plan.push_back('{mk(K_DROP, 10'd5, 31'd0, 31'd0), 1, mkres(ST_INACTIVE, 0)});
    plan.push_back('{mk(K_PARK, 10'd5, 31'd0, 31'd0), 1, mkres(ST_INACTIVE, 0)});
    plan.push_back('{mk(K_UPDATE, 10'd5, 31'd9, 31'd9), 1, mkres(ST_INACTIVE, 0)});
    plan.push_back('{mk(K_APPEND, 10'd0, 31'd0, 31'd0), 1, mkres(ST_OK, 1)});
    plan.push_back('{mk(K_APPEND, 10'd1023, KEY_MAX, KEY_MAX), 0, '0});
    plan.push_back('{mk(K_APPEND, 10'd7, 31'd100, 31'd5), 0, '0});
    plan.push_back('{mk(K_APPEND, 10'd8, 31'd100, 31'd3), 0, '0});
    plan.push_back('{mk(K_APPEND, 10'd0, 31'd50, 31'd50), 0, '0});
    plan.push_back('{mk(K_BUILD, 10'd0, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_UPDATE, 10'd1023, 31'd1, KEY_MAX), 0, '0});
    plan.push_back('{mk(K_PARK, 10'd7, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_PARK, 10'd8, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_UPDATE, 10'd8, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_PEEK, 10'd0, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_APPEND, 10'd9, 31'd2, 31'd2), 0, '0});
    plan.push_back('{mk(K_DROP, 10'd1023, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_DROP, 10'd7, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_RESTORE, 10'd0, 31'd0, 31'd0), 0, '0});
    plan.push_back('{mk(K_NOP, 10'd0, 31'd0, 31'd0), 0, '0});

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send(plan[i].req, plan[i].fixed, plan[i].res, 1'b1);

    // random mix over a small id pool so most requests hit live entries
    for (int n = 0; n < N_RANDOM; n++) begin
      roll = $urandom_range(0, 99);
      rid = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                         : 10'($urandom_range(0, 47));
      r = mk(K_NOP, rid, 31'($urandom_range(0, KEY_MAX)), 31'($urandom_range(0, KEY_MAX)));
      if ($urandom_range(0, 3) == 0) r.cost_bits = 31'($urandom_range(0, 3));
      if (roll < 34) r.kind = K_APPEND;
      else if (roll < 42) r.kind = K_BUILD;
      else if (roll < 58) r.kind = K_UPDATE;
      else if (roll < 70) r.kind = K_DROP;
      else if (roll < 82) r.kind = K_PARK;
      else if (roll < 89) r.kind = K_RESTORE;
      else if (roll < 97) r.kind = K_PEEK;
      if (n == 500) begin
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      send(r, 1'b0, '0, !(n >= 300 && n < 550));
    end
    start = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    $display("%0d requests: append %0d build %0d update %0d drop %0d park %0d",
             n_requests, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4]);
    $display("restore %0d peek %0d nop %0d, %0d mismatches", kind_seen[5],
             kind_seen[6], kind_seen[7], errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hm_pkg.sv
hw/rtl/hm_ram.sv
hw/rtl/indexed_min_heap_with_parking.sv
test/tb_top.sv
